// File: hw/rtl/swt_pkg.sv
`default_nettype none

package swt_pkg;

    localparam int unsigned MAX_RESULTS = 3;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_BAR    = 8'h7c;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_GT     = 8'h3e;
    localparam logic [7:0] CH_LT     = 8'h3c;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_VT     = 8'h0b;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_CR     = 8'h0d;

    localparam logic QK_DOUBLE = 1'b0;
    localparam logic QK_SINGLE = 1'b1;

    typedef enum logic [2:0] {
        MODE_IDLE       = 3'd0,
        MODE_WORD       = 3'd1,
        MODE_WORD_ESC   = 3'd2,
        MODE_QUOTED     = 3'd3,
        MODE_QUOTED_ESC = 3'd4,
        MODE_PEND_AMP   = 3'd5,
        MODE_PEND_BAR   = 3'd6
    } mode_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       has_char;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       token_end;
        logic       operator_token;
        logic       line_done;
    } res_item_t;

    function automatic logic is_space(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    endfunction

    function automatic logic is_oper(input logic [7:0] c);
        return c inside {CH_AMP, CH_BAR, CH_SEMI, CH_LT, CH_GT};
    endfunction

    function automatic res_item_t make_res(input logic [7:0] c, input logic valid,
                                           input logic tend, input logic op);
        res_item_t r;
        r.out_char       = valid ? c : 8'h00;
        r.char_valid     = valid;
        r.token_end      = tend;
        r.operator_token = valid & op;
        r.line_done      = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/shell_word_tokenizer.sv
// Streaming shell command-line lexer. Each input transfer carries one byte (or an end-only
// marker); each output transfer carries one token character or an end-of-token mark, with
// line_done on the last result of a line. A byte is registered on input, decoded
// combinationally against the lexer state, and its zero to three results go into a four-entry
// result queue that drives the output. While the output is not stalled, the block takes one
// item per cycle as long as at most one result per item is produced on average; items with
// two or three results (operator pairs, flushes at end of line) take one output transfer per
// result, and input is held off while the queue has fewer than three free entries. An item
// passes through the input register and then the result queue before its first result is out.
`default_nettype none

module shell_word_tokenizer (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  swt_pkg::in_item_t     s_data,
    output logic                  m_valid,
    input  wire                   m_ready,
    output swt_pkg::res_item_t    m_data
);
    import swt_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic                 in_valid_reg;
    in_item_t             in_data_reg;
    mode_t                mode_reg, mode_next;
    logic                 quote_reg, quote_next;

    res_item_t            queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;

    res_item_t            slot [MAX_RESULTS];
    logic [1:0]           n_res;
    logic                 advance;
    logic                 pop;

    assign advance = in_valid_reg && (count_reg <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS));
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = (count_reg != '0);
    assign m_data  = queue_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    // decode one item into up to three results
    always_comb begin
        logic [7:0] c;
        logic [7:0] p;
        logic       run_idle;
        logic       run_word;
        mode_t      md;
        logic       qk;
        logic [1:0] cnt;

        c        = in_data_reg.char_byte;
        md       = mode_reg;
        qk       = quote_reg;
        cnt      = 2'd0;
        run_idle = 1'b0;
        run_word = 1'b0;
        p        = (mode_reg == MODE_PEND_AMP) ? CH_AMP : CH_BAR;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            slot[i] = '0;
        end

        if (in_data_reg.has_char) begin
            case (mode_reg)
                MODE_WORD: begin
                    if (is_space(c) || is_oper(c)) begin
                        slot[cnt] = make_res(8'h00, 1'b0, 1'b1, 1'b0);
                        cnt = cnt + 2'd1;
                        run_idle = 1'b1;
                    end else begin
                        run_word = 1'b1;
                    end
                end
                MODE_WORD_ESC: begin
                    slot[cnt] = make_res(c, 1'b1, 1'b0, 1'b0);
                    cnt = cnt + 2'd1;
                    md = MODE_WORD;
                end
                MODE_QUOTED: begin
                    if (c == CH_BSLASH) begin
                        md = MODE_QUOTED_ESC;
                    end else if (c == ((qk == QK_SINGLE) ? CH_SQUOTE : CH_DQUOTE)) begin
                        md = MODE_WORD;
                    end else begin
                        slot[cnt] = make_res(c, 1'b1, 1'b0, 1'b0);
                        cnt = cnt + 2'd1;
                    end
                end
                MODE_QUOTED_ESC: begin
                    slot[cnt] = make_res(c, 1'b1, 1'b0, 1'b0);
                    cnt = cnt + 2'd1;
                    md = MODE_QUOTED;
                end
                MODE_PEND_AMP, MODE_PEND_BAR: begin
                    if (c == p) begin
                        slot[cnt] = make_res(p, 1'b1, 1'b0, 1'b1);
                        cnt = cnt + 2'd1;
                        slot[cnt] = make_res(c, 1'b1, 1'b1, 1'b1);
                        cnt = cnt + 2'd1;
                        md = MODE_IDLE;
                    end else begin
                        slot[cnt] = make_res(p, 1'b1, 1'b1, 1'b1);
                        cnt = cnt + 2'd1;
                        run_idle = 1'b1;
                    end
                end
                default: begin
                    run_idle = 1'b1;
                end
            endcase

            if (run_idle) begin
                md = MODE_IDLE;
                if (!is_space(c)) begin
                    if (c == CH_AMP) begin
                        md = MODE_PEND_AMP;
                    end else if (c == CH_BAR) begin
                        md = MODE_PEND_BAR;
                    end else if (c inside {CH_SEMI, CH_LT, CH_GT}) begin
                        slot[cnt] = make_res(c, 1'b1, 1'b1, 1'b1);
                        cnt = cnt + 2'd1;
                    end else begin
                        run_word = 1'b1;
                    end
                end
            end

            if (run_word) begin
                if (c == CH_BSLASH) begin
                    md = MODE_WORD_ESC;
                end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
                    qk = (c == CH_SQUOTE) ? QK_SINGLE : QK_DOUBLE;
                    md = MODE_QUOTED;
                end else begin
                    slot[cnt] = make_res(c, 1'b1, 1'b0, 1'b0);
                    cnt = cnt + 2'd1;
                    md = MODE_WORD;
                end
            end
        end

        if (in_data_reg.end_of_input) begin
            case (md)
                MODE_WORD, MODE_QUOTED: begin
                    slot[cnt] = make_res(8'h00, 1'b0, 1'b1, 1'b0);
                    cnt = cnt + 2'd1;
                end
                MODE_WORD_ESC, MODE_QUOTED_ESC: begin
                    // trailing backslash stays literal
                    slot[cnt] = make_res(CH_BSLASH, 1'b1, 1'b0, 1'b0);
                    cnt = cnt + 2'd1;
                    slot[cnt] = make_res(8'h00, 1'b0, 1'b1, 1'b0);
                    cnt = cnt + 2'd1;
                end
                MODE_PEND_AMP: begin
                    slot[cnt] = make_res(CH_AMP, 1'b1, 1'b1, 1'b1);
                    cnt = cnt + 2'd1;
                end
                MODE_PEND_BAR: begin
                    slot[cnt] = make_res(CH_BAR, 1'b1, 1'b1, 1'b1);
                    cnt = cnt + 2'd1;
                end
                default: begin
                end
            endcase
            if (cnt == 2'd0) begin
                slot[cnt] = make_res(8'h00, 1'b0, 1'b0, 1'b0);
                cnt = cnt + 2'd1;
            end
            slot[cnt - 2'd1].line_done = 1'b1;
            md = MODE_IDLE;
            qk = QK_DOUBLE;
        end

        mode_next  = md;
        quote_next = qk;
        n_res      = cnt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            mode_reg     <= MODE_IDLE;
            quote_reg    <= QK_DOUBLE;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                mode_reg   <= mode_next;
                quote_reg  <= quote_next;
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(advance ? n_res : 2'd0);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + CNT_W'(advance ? n_res : 2'd0) - CNT_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (advance && (2'(i) < n_res)) begin
                queue_reg[wr_ptr_reg + PTR_W'(i)] <= slot[i];
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/swt_checker.sv
`default_nettype none

module swt_checker (
    input wire                 aclk,
    input wire                 aresetn,
    input wire                 m_valid,
    input wire                 m_ready,
    input swt_pkg::res_item_t  m_data
);
    import swt_pkg::*;

    // stalled result transfer keeps valid
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result valid dropped while stalled");

    // operator flag only on carried characters
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.operator_token && !m_data.char_valid))
        else $error("operator flag without character");

    // end marks carry no character byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.char_valid |-> m_data.out_char == 8'h00)
        else $error("nonzero byte on result without character");

    // nothing on the result channel right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind shell_word_tokenizer swt_checker u_swt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
